// File: src/ccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and calendar helpers for the calendar clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  localparam int unsigned FieldsW = YearW + MonthW + DayW + HourW + MinW + SecW;
  localparam int unsigned DataW   = ((FieldsW + 7) / 8) * 8;

  // tdata bit offsets, lowest field first
  localparam int unsigned YearLsb  = 0;
  localparam int unsigned MonthLsb = YearLsb + YearW;
  localparam int unsigned DayLsb   = MonthLsb + MonthW;
  localparam int unsigned HourLsb  = DayLsb + DayW;
  localparam int unsigned MinLsb   = HourLsb + HourW;
  localparam int unsigned SecLsb   = MinLsb + MinW;

  localparam logic [YearW-1:0]  YearRst  = YearW'(2025);
  localparam logic [MonthW-1:0] MonthRst = MonthW'(1);
  localparam logic [DayW:0]     DayRst   = (DayW + 1)'(1);
  localparam logic [HourW-1:0]  HourRst  = HourW'(12);
  localparam logic [MinW-1:0]   MinRst   = MinW'(0);
  localparam logic [SecW-1:0]   SecRst   = SecW'(0);

  localparam logic [SecW-1:0]   SecPerMin  = SecW'(60);
  localparam logic [MinW:0]     MinPerHour = (MinW + 1)'(60);
  localparam logic [HourW:0]    HourPerDay = (HourW + 1)'(24);
  localparam logic [MonthW-1:0] MonthDec   = MonthW'(12);

  // year mod 25 by reciprocal: q = (y * Recip25) >> Recip25Shift, low by at most one
  localparam int unsigned Recip25Shift = 20;
  localparam logic [15:0] Recip25      = 16'd41943;
  localparam int unsigned ProdW        = YearW + 16;
  localparam int unsigned QuotW        = ProdW - Recip25Shift;
  localparam logic [4:0]  Div25        = 5'd25;

  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonNov = MonthW'(11);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAP,
    ST_ROLL
  } ctrl_state_e;

  typedef struct packed {
    logic load;   // take the input item, apply sec/min/hour carries
    logic leap;   // resolve the leap-year flag
    logic roll;   // month rollover and result register update
  } ctrl_cmd_t;

  // days in month; invalid months count as 31
  function automatic logic [DayW-1:0] month_days(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] d;
    unique case (m) inside
      MonFeb:                         d = DayW'(28) + DayW'(leap);
      MonApr, MonJun, MonSep, MonNov: d = DayW'(30);
      default:                        d = DayW'(31);
    endcase
    return d;
  endfunction

endpackage

// File: src/ccc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_ctrl
// Sequencer: accepts an item, steps the datapath and owns the result valid.
// ----------------------------------------------------------------------------
module ccc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ccc_pkg::ctrl_cmd_t    cmd_o
);

  ccc_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ccc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ccc_pkg::ST_LEAP;
        end
      end
      ccc_pkg::ST_LEAP: begin
        cmd_o.leap = 1'b1;
        state_d    = ccc_pkg::ST_ROLL;
      end
      ccc_pkg::ST_ROLL: begin
        if (slot_free) begin
          cmd_o.roll = 1'b1;
          state_d    = ccc_pkg::ST_IDLE;
        end
      end
      default: state_d = ccc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.roll) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/ccc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_datapath
// Time registers, carry chain, leap-year unit, month rollover, result register.
// ----------------------------------------------------------------------------
module ccc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ccc_pkg::ctrl_cmd_t          cmd_i,
  input  logic                        mode_i,
  input  logic [ccc_pkg::DataW-1:0]   in_data_i,
  output logic [ccc_pkg::DataW-1:0]   out_data_o
);

  localparam int unsigned YW = ccc_pkg::YearW;
  localparam int unsigned MW = ccc_pkg::MonthW;
  localparam int unsigned DW = ccc_pkg::DayW;
  localparam int unsigned HW = ccc_pkg::HourW;
  localparam int unsigned NW = ccc_pkg::MinW;
  localparam int unsigned SW = ccc_pkg::SecW;

  logic [YW-1:0] yr_q,  yr_d;
  logic [MW-1:0] mo_q,  mo_d;
  logic [DW:0]   dy_q,  dy_d;
  logic [HW-1:0] hr_q,  hr_d;
  logic [NW-1:0] min_q, min_d;
  logic [SW-1:0] sec_q, sec_d;
  logic [ccc_pkg::ProdW-1:0] prod_q, prod_d;
  logic          leap_q, leap_d;
  logic [ccc_pkg::DataW-1:0] out_q, out_d;

  // load stage
  logic [YW-1:0] yr_sel;
  logic [MW-1:0] mo_sel;
  logic [DW-1:0] dy_sel;
  logic [HW-1:0] hr_sel;
  logic [NW-1:0] min_sel;
  logic [SW-1:0] sec_sel;
  logic          sec_c, min_c, hr_c;
  logic [NW:0]   min_sum;
  logic [HW:0]   hr_sum;
  logic [SW-1:0] sec_n;
  logic [NW-1:0] min_n;
  logic [HW-1:0] hr_n;
  logic [DW:0]   dy_n;

  // leap stage
  logic [ccc_pkg::QuotW-1:0] quot;
  logic [YW-1:0]             q25;
  logic [YW-1:0]             rem, rem_c;
  logic                      div25, div4, div16;

  // roll stage
  logic [DW-1:0] dim;
  logic          over;
  logic [YW-1:0] yr_r;
  logic [MW-1:0] mo_r;
  logic [DW:0]   dy_r;

  always_comb begin
    yr_sel  = mode_i ? in_data_i[ccc_pkg::YearLsb  +: YW] : yr_q;
    mo_sel  = mode_i ? in_data_i[ccc_pkg::MonthLsb +: MW] : mo_q;
    dy_sel  = mode_i ? in_data_i[ccc_pkg::DayLsb   +: DW] : dy_q[DW-1:0];
    hr_sel  = mode_i ? in_data_i[ccc_pkg::HourLsb  +: HW] : hr_q;
    min_sel = mode_i ? in_data_i[ccc_pkg::MinLsb   +: NW] : min_q;
    sec_sel = mode_i ? in_data_i[ccc_pkg::SecLsb   +: SW] : sec_q + SW'(1);

    sec_c   = sec_sel >= ccc_pkg::SecPerMin;
    sec_n   = sec_c ? sec_sel - ccc_pkg::SecPerMin : sec_sel;
    min_sum = {1'b0, min_sel} + (NW + 1)'(sec_c);
    min_c   = min_sum >= ccc_pkg::MinPerHour;
    min_n   = min_c ? NW'(min_sum - ccc_pkg::MinPerHour) : min_sum[NW-1:0];
    hr_sum  = {1'b0, hr_sel} + (HW + 1)'(min_c);
    hr_c    = hr_sum >= ccc_pkg::HourPerDay;
    hr_n    = hr_c ? HW'(hr_sum - ccc_pkg::HourPerDay) : hr_sum[HW-1:0];
    dy_n    = {1'b0, dy_sel} + (DW + 1)'(hr_c);
    prod_d  = ccc_pkg::ProdW'(yr_sel) * ccc_pkg::ProdW'(ccc_pkg::Recip25);
  end

  always_comb begin
    quot   = prod_q[ccc_pkg::ProdW-1 -: ccc_pkg::QuotW];
    q25    = YW'(quot) * YW'(ccc_pkg::Div25);
    rem    = yr_q - q25;
    rem_c  = (rem >= YW'(ccc_pkg::Div25)) ? rem - YW'(ccc_pkg::Div25) : rem;
    div25  = rem_c == '0;
    div4   = yr_q[1:0] == 2'b00;
    div16  = yr_q[3:0] == 4'b0000;
    leap_d = div4 && (!div25 || div16);
  end

  always_comb begin
    dim  = ccc_pkg::month_days(mo_q, leap_q);
    over = dy_q > {1'b0, dim};
    yr_r = yr_q;
    mo_r = mo_q;
    dy_r = dy_q;
    if (over) begin
      dy_r = dy_q - {1'b0, dim};
      if (mo_q >= ccc_pkg::MonthDec) begin
        mo_r = MW'(1);
        yr_r = yr_q + YW'(1);
      end else begin
        mo_r = mo_q + MW'(1);
      end
    end
    out_d = ccc_pkg::DataW'({sec_q, min_q, hr_q, dy_r[DW-1:0], mo_r, yr_r});
  end

  always_comb begin
    yr_d  = yr_q;
    mo_d  = mo_q;
    dy_d  = dy_q;
    hr_d  = hr_q;
    min_d = min_q;
    sec_d = sec_q;
    if (cmd_i.load) begin
      yr_d  = yr_sel;
      mo_d  = mo_sel;
      dy_d  = dy_n;
      hr_d  = hr_n;
      min_d = min_n;
      sec_d = sec_n;
    end else if (cmd_i.roll) begin
      yr_d = yr_r;
      mo_d = mo_r;
      dy_d = dy_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yr_q  <= ccc_pkg::YearRst;
      mo_q  <= ccc_pkg::MonthRst;
      dy_q  <= ccc_pkg::DayRst;
      hr_q  <= ccc_pkg::HourRst;
      min_q <= ccc_pkg::MinRst;
      sec_q <= ccc_pkg::SecRst;
    end else begin
      yr_q  <= yr_d;
      mo_q  <= mo_d;
      dy_q  <= dy_d;
      hr_q  <= hr_d;
      min_q <= min_d;
      sec_q <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_q <= prod_d;
    end
    if (cmd_i.leap) begin
      leap_q <= leap_d;
    end
    if (cmd_i.roll) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: src/calendar_clock_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_counter
// Calendar clock: one-second ticks or set-time loads, normalized with the
// Gregorian leap-year rule; the full time is returned after every item.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                  | tuser
// s_axis  | in  | set_year..set_second, 42 bits in 48    | mode
// m_axis  | out | year..second, 42 bits in 48            | -
//
// Each item passes three steps: accept with carries, leap-year check (reciprocal
// multiply for year mod 25), then month rollover into the result register.
// Input is taken again right after the rollover cycle; a result still waiting
// on m_axis holds the next item in its rollover cycle until it is taken.
// Reset puts the clock at 2025-01-01 12:00:00 with no result pending.
// ----------------------------------------------------------------------------
module calendar_clock_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // set_year, set_month, set_day, set_hour, set_minute, set_second, zero pad
  input  logic [ccc_pkg::DataW-1:0] s_axis_tdata_i,
  // mode
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // year, month, day, hour, minute, second, zero pad
  output logic [ccc_pkg::DataW-1:0] m_axis_tdata_o
);

  ccc_pkg::ctrl_cmd_t cmd;

  ccc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  ccc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mode_i     (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while previous item in flight");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[ccc_pkg::SecLsb +: ccc_pkg::SecW] < ccc_pkg::SecPerMin &&
      m_axis_tdata_o[ccc_pkg::MinLsb +: ccc_pkg::MinW] < ccc_pkg::SecPerMin)
    else $error("second or minute out of range");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      {1'b0, m_axis_tdata_o[ccc_pkg::HourLsb +: ccc_pkg::HourW]} < ccc_pkg::HourPerDay)
    else $error("hour out of range");

  a_roll_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.roll |=> m_axis_tvalid_o && s_axis_tready_o)
    else $error("result not presented after rollover");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Self-checking bench for calendar_clock_counter
// Drives one-second ticks and time loads on s_axis, predicts the normalized
// calendar time after every item and compares each m_axis result field by
// field. A directed table covers field extremes, leap and century years,
// invalid months, day zero and year wrap; random boundary-seeking load and
// tick sequences follow, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module testbench;
  import ccc_pkg::*;

  localparam bit MODE_TICK = 1'b0;
  localparam bit MODE_LOAD = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned DRAIN_LIMIT  = 4000;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } clock_time_t;

  typedef struct packed {
    bit          mode;
    clock_time_t load;
    bit          known;
    clock_time_t want;
  } directed_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i;
  logic             s_axis_tuser_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [DataW-1:0] m_axis_tdata_o;

  clock_time_t   expected_times[$];
  clock_time_t   clock_now;
  directed_row_t plan[$];
  int unsigned   mismatch_count;
  int unsigned   ticks_sent;
  int unsigned   loads_sent;
  int unsigned   results_seen;
  int unsigned   month_turns;
  int unsigned   year_turns;
  int unsigned   burst_left;
  logic [15:0]   stall_pattern;
  int unsigned   stall_phase;

  calendar_clock_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic clock_time_t at(int unsigned y, int unsigned mo, int unsigned d,
                                     int unsigned h, int unsigned mi, int unsigned s);
    clock_time_t t;
    t.year   = y & 16'hFFFF;
    t.month  = mo & 4'hF;
    t.day    = d & 5'h1F;
    t.hour   = h & 5'h1F;
    t.minute = mi & 6'h3F;
    t.second = s & 6'h3F;
    return t;
  endfunction

  function automatic directed_row_t row(bit mode, clock_time_t load, bit known,
                                        clock_time_t want);
    directed_row_t r;
    r.mode  = mode;
    r.load  = load;
    r.known = known;
    r.want  = want;
    return r;
  endfunction

  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    if (m == 2) begin
      return is_leap(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // carry sec -> min -> hour -> day, then walk months until the day fits
  function automatic clock_time_t roll_clock(int unsigned sec, int unsigned min,
                                             int unsigned hr, int unsigned dy,
                                             int unsigned mo, int unsigned yr);
    int unsigned dim;
    int          guard;
    bit          fits;
    min   = min + sec / 60;
    sec   = sec % 60;
    hr    = hr + min / 60;
    min   = min % 60;
    dy    = dy + hr / 24;
    hr    = hr % 24;
    guard = 0;
    fits  = 1'b0;
    while (guard < 8 && !fits) begin
      dim = days_in(mo, yr);
      if (dy <= dim) begin
        fits = 1'b1;
      end else begin
        dy = dy - dim;
        mo = (mo + 1) & 32'h1F;
        month_turns++;
        if (mo > 12) begin
          mo = 1;
          yr = (yr + 1) & 32'hFFFF;
          year_turns++;
        end
        guard++;
      end
    end
    return at(yr, mo, dy, hr, min, sec);
  endfunction

  function automatic clock_time_t advance_clock(bit mode, clock_time_t load);
    if (mode == MODE_LOAD) begin
      clock_now = roll_clock(load.second, load.minute, load.hour, load.day,
                             load.month, load.year);
    end else begin
      clock_now = roll_clock(clock_now.second + 1, clock_now.minute, clock_now.hour,
                             clock_now.day, clock_now.month, clock_now.year);
    end
    return clock_now;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_item(bit mode, clock_time_t load, bit known, clock_time_t want);
    logic [DataW-1:0] word;
    logic [63:0]      rnd;
    clock_time_t      predicted;
    if (mode == MODE_TICK) begin
      rnd  = {$urandom(), $urandom()};
      load = rnd[$bits(clock_time_t)-1:0];
    end
    word = '0;
    word[YearLsb +: YearW]   = load.year;
    word[MonthLsb +: MonthW] = load.month;
    word[DayLsb +: DayW]     = load.day;
    word[HourLsb +: HourW]   = load.hour;
    word[MinLsb +: MinW]     = load.minute;
    word[SecLsb +: SecW]     = load.second;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = advance_clock(mode, load);
    expected_times.push_back(known ? want : predicted);
    if (mode == MODE_LOAD) begin
      loads_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    int unsigned waited;
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (expected_times.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_times.size() != 0) begin
      $error("%0d results never arrived", expected_times.size());
      mismatch_count++;
      expected_times.delete();
    end
  endtask

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 65535);
      1:       return 400 * $urandom_range(0, 163);
      2:       return 100 * $urandom_range(0, 655);
      3:       return 4 * $urandom_range(0, 16383);
      default: return ($urandom_range(0, 1) == 0) ? 65535 : 0;
    endcase
  endfunction

  // output side stall pattern, reshuffled at random
  always @(posedge clk_i) begin
    if (stall_phase % 64 == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        stall_pattern = 16'hFFFF;
      end else begin
        stall_pattern = $urandom_range(0, 65535) | 16'h0001;
      end
    end
    m_axis_tready_i <= stall_pattern[stall_phase % 16];
    stall_phase++;
  end

  always @(posedge clk_i) begin
    clock_time_t seen;
    clock_time_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.year   = m_axis_tdata_o[YearLsb +: YearW];
      seen.month  = m_axis_tdata_o[MonthLsb +: MonthW];
      seen.day    = m_axis_tdata_o[DayLsb +: DayW];
      seen.hour   = m_axis_tdata_o[HourLsb +: HourW];
      seen.minute = m_axis_tdata_o[MinLsb +: MinW];
      seen.second = m_axis_tdata_o[SecLsb +: SecW];
      results_seen++;
      if (expected_times.size() == 0) begin
        $error("result %0h arrived with nothing expected", seen);
        mismatch_count++;
      end else begin
        want = expected_times.pop_front();
        check_field("year", want.year, seen.year);
        check_field("month", want.month, seen.month);
        check_field("day", want.day, seen.day);
        check_field("hour", want.hour, seen.hour);
        check_field("minute", want.minute, seen.minute);
        check_field("second", want.second, seen.second);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clock_time_t load;
    logic [63:0] rnd;
    int unsigned random_sent;
    int unsigned run;
    int unsigned yr;
    int unsigned mo;
    bit          drained_mid;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = MODE_TICK;
    m_axis_tready_i = 1'b0;
    stall_pattern   = 16'hFFFF;
    stall_phase     = 0;
    burst_left      = 0;
    mismatch_count  = 0;
    ticks_sent      = 0;
    loads_sent      = 0;
    results_seen    = 0;
    month_turns     = 0;
    year_turns      = 0;
    clock_now       = at(2025, 1, 1, 12, 0, 0);

    plan.push_back(row(MODE_TICK, '0, 1'b1, at(2025, 1, 1, 12, 0, 1)));
    plan.push_back(row(MODE_LOAD, at(65535, 15, 31, 31, 63, 63), 1'b1, at(0, 1, 1, 8, 4, 3)));
    plan.push_back(row(MODE_LOAD, at(0, 0, 0, 0, 0, 0), 1'b1, at(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(65535, 12, 31, 23, 59, 59), 1'b1,
                       at(65535, 12, 31, 23, 59, 59)));
    plan.push_back(row(MODE_TICK, '0, 1'b1, at(0, 1, 1, 0, 0, 0)));
    plan.push_back(row(MODE_LOAD, at(2024, 2, 28, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(2023, 2, 28, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(1900, 2, 28, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(2000, 2, 28, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(0, 2, 28, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(7, 0, 31, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(7, 13, 31, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(7, 14, 31, 23, 59, 58), 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(2025, 3, 0, 23, 59, 59), 1'b0, '0));
    plan.push_back(row(MODE_TICK, '0, 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(2025, 4, 30, 23, 59, 60), 1'b0, '0));
    plan.push_back(row(MODE_LOAD, at(2025, 6, 30, 24, 0, 0), 1'b0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_item(plan[i].mode, plan[i].load, plan[i].known, plan[i].want);
      pace_sender();
    end
    wait_drained();

    random_sent = 0;
    drained_mid = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        rnd  = {$urandom(), $urandom()};
        load = rnd[$bits(clock_time_t)-1:0];
      end else begin
        yr = pick_year();
        mo = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 15) * $urandom_range(0, 1)
                                         : $urandom_range(1, 12);
        load = at(yr, mo, days_in(mo, yr) - $urandom_range(0, 1),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
                  $urandom_range(45, 59));
        if ($urandom_range(0, 9) == 0) begin
          load.day = $urandom_range(0, 31);
        end
      end
      send_item(MODE_LOAD, load, 1'b0, '0);
      pace_sender();
      random_sent++;
      run = $urandom_range(1, 25);
      repeat (run) begin
        send_item(MODE_TICK, '0, 1'b0, '0);
        pace_sender();
        random_sent++;
      end
      if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d ticks and %0d time loads, %0d results compared",
             ticks_sent, loads_sent, results_seen);
    $display("calendar walked %0d month turns and %0d year turns",
             month_turns, year_turns);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
